// ===== design/apf_pkg.sv =====
package apf_pkg;

    // field widths
    localparam int unsigned POS_W    = 32;
    localparam int unsigned OUT_POS_W = 33;
    localparam int unsigned ERR_W    = 34;
    localparam int unsigned MAG_W    = 33;
    localparam int unsigned TOL_W    = 16;
    localparam int unsigned DRV_W    = 15;
    localparam int unsigned DRIVE_W  = 16;
    localparam int unsigned PROD_W   = MAG_W + DRV_W;
    localparam int unsigned DIV_W    = TOL_W + 1;
    localparam int unsigned DSH_W    = DIV_W + DRV_W;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned PC_W     = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // defaults
    localparam int unsigned NUM_AXES_DEF = 2;
    localparam logic [DRV_W-1:0] MAX_DRIVE = 15'd1000;
    localparam logic [CNT_W-1:0] LOOP_TOP  = 4'(DRV_W - 1);

    // mode commands
    localparam logic [1:0] CMD_STOP   = 2'd0;
    localparam logic [1:0] CMD_FOLLOW = 2'd1;
    localparam logic [1:0] CMD_FAST   = 2'd2;
    localparam logic [1:0] CMD_HOME   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_TOL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_TOL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_FOLLOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_FOLLOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd7;

    // microcode addresses
    localparam logic [PC_W-1:0] PC_POS  = 3'd0;
    localparam logic [PC_W-1:0] PC_ERR  = 3'd1;
    localparam logic [PC_W-1:0] PC_MAG  = 3'd2;
    localparam logic [PC_W-1:0] PC_CLR  = 3'd3;
    localparam logic [PC_W-1:0] PC_MUL  = 3'd4;
    localparam logic [PC_W-1:0] PC_DCHK = 3'd5;
    localparam logic [PC_W-1:0] PC_DIV  = 3'd6;
    localparam logic [PC_W-1:0] PC_FIN  = 3'd7;

    typedef enum logic [3:0] {
        OP_NOP, OP_POS, OP_ERR, OP_MAG, OP_CLR, OP_MUL, OP_DCHK, OP_DIV, OP_FIN
    } t_op;

    typedef enum logic [1:0] {
        C_NONE, C_NOPROP, C_LOOP, C_SAT
    } t_cond;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_seq_state;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic noprop;
        logic sat;
        logic cnt_nz;
        logic out_stall;
    } t_flags;

    // control store
    function automatic t_ctrl rom_word(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{op: OP_NOP, cond: C_NONE, target: PC_POS};
        case (pc)
            PC_POS:  w = '{op: OP_POS,  cond: C_NONE,   target: PC_POS};
            PC_ERR:  w = '{op: OP_ERR,  cond: C_NONE,   target: PC_POS};
            PC_MAG:  w = '{op: OP_MAG,  cond: C_NONE,   target: PC_POS};
            PC_CLR:  w = '{op: OP_CLR,  cond: C_NOPROP, target: PC_FIN};
            PC_MUL:  w = '{op: OP_MUL,  cond: C_LOOP,   target: PC_MUL};
            PC_DCHK: w = '{op: OP_DCHK, cond: C_SAT,    target: PC_FIN};
            PC_DIV:  w = '{op: OP_DIV,  cond: C_LOOP,   target: PC_DIV};
            PC_FIN:  w = '{op: OP_FIN,  cond: C_NONE,   target: PC_POS};
            default: w = '{op: OP_NOP,  cond: C_NONE,   target: PC_POS};
        endcase
        return w;
    endfunction

endpackage

// ===== design/apf_if.sv =====
interface apf_in_if;
    logic               valid;
    logic               ready;
    logic               axis;
    logic [1:0]         cmd;
    logic signed [31:0] target;
    logic signed [31:0] encoder_count;
    logic               limit_switch;

    modport source (output valid, axis, cmd, target, encoder_count, limit_switch,
                    input ready);
    modport sink   (input valid, axis, cmd, target, encoder_count, limit_switch,
                    output ready);
endinterface

interface apf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;
    logic               done_res;
    logic signed [32:0] position;
    logic               axis_out;

    modport source (output valid, drive, done_res, position, axis_out, input ready);
    modport sink   (input valid, drive, done_res, position, axis_out, output ready);
endinterface

// ===== design/apf_seq.sv =====
module apf_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  apf_pkg::t_flags i_flags,
    output logic            o_idle,
    output apf_pkg::t_ctrl  o_ctrl
);
    import apf_pkg::*;

    t_seq_state      r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_ctrl           w;
    logic            take;

    always_comb begin
        w = rom_word(r_pc);
        case (w.cond)
            C_NONE:   take = 1'b0;
            C_NOPROP: take = i_flags.noprop;
            C_LOOP:   take = i_flags.cnt_nz;
            C_SAT:    take = i_flags.sat;
            default:  take = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            S_IDLE: begin
                n_pc = PC_POS;
                if (i_start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w.op == OP_FIN) begin
                    if (!i_flags.out_stall) begin
                        n_state = S_IDLE;
                        n_pc    = PC_POS;
                    end
                end else if (take) begin
                    n_pc = w.target;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_pc    = PC_POS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= PC_POS;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_ctrl = (r_state == S_RUN) ? w
                  : t_ctrl'{op: OP_NOP, cond: C_NONE, target: PC_POS};

endmodule

// ===== design/axis_position_follow_and_homing.sv =====
// channel  dir  handshake      payload
// i_in     in   valid/ready    axis, cmd, target, encoder_count, limit_switch
// o_out    out  valid/ready    drive, done_res, position, axis_out
// i_cfg    in   write enable   i_cfg_index (3b), i_cfg_data (16b), no read-back
//
// one beat at a time: a microcoded sequencer walks each tick through the datapath
// stop, follow, homing, small-error fast follow: position, error, magnitude, clear, finish
// proportional fast follow adds 15 shift-add multiply steps and 15 restoring
// divide steps on a 48-bit accumulator; a quotient sure to pass the limit skips the divide
// result sits in an output register; the next beat is taken while it waits
// a stalled output holds the sequencer on its last step; reset is synchronous, no sweep
module axis_position_follow_and_homing #(
    parameter int unsigned NUM_AXES = apf_pkg::NUM_AXES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    apf_in_if.sink                           i_in,
    apf_out_if.source                        o_out,
    input  logic                             i_cfg_wr_en,
    input  logic [apf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [apf_pkg::CFG_DAT_W-1:0]    i_cfg_data
);
    import apf_pkg::*;

    // configuration, one set for each of the two axes
    logic [TOL_W-1:0] r_tol    [2];
    logic [TOL_W-1:0] r_thr    [2];
    logic [DRV_W-1:0] r_follow [2];
    logic [DRV_W-1:0] r_origin [2];

    // homing offset per axis
    logic signed [POS_W-1:0] r_offset [NUM_AXES];

    // captured beat
    logic                    r_ax;
    logic [1:0]              r_cmd;
    logic signed [POS_W-1:0] r_tgt;
    logic signed [POS_W-1:0] r_enc;
    logic                    r_sw;

    // working registers
    logic signed [OUT_POS_W-1:0] r_pos;
    logic signed [ERR_W-1:0]     r_err;
    logic [MAG_W-1:0]            r_mag;
    logic                        r_inside;
    logic                        r_prop;
    logic [PROD_W-1:0]           r_acc;
    logic [DSH_W-1:0]            r_dsh;
    logic [DRV_W-1:0]            r_q;
    logic                        r_sat;
    logic [CNT_W-1:0]            r_cnt;

    // output register
    logic                        r_out_valid;
    logic signed [DRIVE_W-1:0]   r_out_drive;
    logic                        r_out_done;
    logic signed [OUT_POS_W-1:0] r_out_pos;
    logic                        r_out_ax;

    t_ctrl  ctrl;
    t_flags flags;
    logic   seq_idle;
    logic   in_fire;
    logic   fin_fire;

    // per-axis selections
    logic                    ax_ok;
    logic signed [POS_W-1:0] off_sel;
    logic [TOL_W-1:0]        tol_sel;
    logic [TOL_W-1:0]        thr_sel;
    logic [DRV_W-1:0]        follow_sel;
    logic [DRV_W-1:0]        origin_sel;
    logic [DIV_W-1:0]        dvsr;

    logic                    inside_c;
    logic                    prop_c;
    logic                    sat_c;
    logic                    ge_c;
    logic [PROD_W-1:0]       mul_next;

    // final result
    logic                        err_pos;
    logic [DRV_W-1:0]            q_lo;
    logic [DRV_W-1:0]            q_fin;
    logic [DRV_W-1:0]            mag_out;
    logic                        neg_out;
    logic                        done_out;
    logic signed [OUT_POS_W-1:0] pos_out;
    logic                        capture;
    logic signed [DRIVE_W-1:0]   drive_out;

    assign in_fire  = i_in.valid && seq_idle;
    assign i_in.ready = seq_idle;
    assign fin_fire = (ctrl.op == OP_FIN) && !(r_out_valid && !o_out.ready);

    apf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire),
        .i_flags (flags),
        .o_idle  (seq_idle),
        .o_ctrl  (ctrl)
    );

    // axis beyond the offset table passes the raw count through
    assign ax_ok = (NUM_AXES > 1) || (r_ax == 1'b0);

    always_comb begin
        off_sel = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (r_ax == 1'(i)) begin
                off_sel = r_offset[i];
            end
        end
        if (!ax_ok) begin
            off_sel = '0;
        end
    end

    assign tol_sel    = r_tol[r_ax];
    assign thr_sel    = r_thr[r_ax];
    assign follow_sel = r_follow[r_ax];
    assign origin_sel = r_origin[r_ax];
    assign dvsr       = {thr_sel, 1'b0};

    // branch conditions
    assign inside_c = r_mag < {{(MAG_W - TOL_W){1'b0}}, tol_sel};
    assign prop_c   = (r_cmd == CMD_FAST) && !inside_c
                   && (r_mag > {{(MAG_W - TOL_W){1'b0}}, thr_sel});
    // quotient of 2^15 or more always hits the limit; zero divisor lands here too
    assign sat_c    = r_acc >= {{(PROD_W - DSH_W){1'b0}}, dvsr, {DRV_W{1'b0}}};
    assign ge_c     = r_acc >= {{(PROD_W - DSH_W){1'b0}}, r_dsh};
    assign mul_next = {r_acc[PROD_W-2:0], 1'b0}
                    + (follow_sel[r_cnt] ? {{(PROD_W - MAG_W){1'b0}}, r_mag} : '0);

    assign flags = '{noprop:    !prop_c,
                     sat:       sat_c,
                     cnt_nz:    (r_cnt != '0),
                     out_stall: r_out_valid && !o_out.ready};

    // datapath steps
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ax  <= i_in.axis;
            r_cmd <= i_in.cmd;
            r_tgt <= i_in.target;
            r_enc <= i_in.encoder_count;
            r_sw  <= i_in.limit_switch;
        end
        case (ctrl.op)
            OP_POS: begin
                r_pos <= {r_enc[POS_W-1], r_enc} - {off_sel[POS_W-1], off_sel};
            end
            OP_ERR: begin
                r_err <= {{(ERR_W - POS_W){r_tgt[POS_W-1]}}, r_tgt}
                       - {{(ERR_W - OUT_POS_W){r_pos[OUT_POS_W-1]}}, r_pos};
            end
            OP_MAG: begin
                r_mag <= r_err[ERR_W-1] ? MAG_W'(-r_err) : MAG_W'(r_err);
            end
            OP_CLR: begin
                r_inside <= inside_c;
                r_prop   <= prop_c;
                r_acc    <= '0;
                r_cnt    <= LOOP_TOP;
            end
            OP_MUL: begin
                r_acc <= mul_next;
                r_cnt <= r_cnt - 1'b1;
            end
            OP_DCHK: begin
                r_sat <= sat_c;
                r_dsh <= {1'b0, dvsr, {(DRV_W - 1){1'b0}}};
                r_q   <= '0;
                r_cnt <= LOOP_TOP;
            end
            OP_DIV: begin
                if (ge_c) begin
                    r_acc <= r_acc - {{(PROD_W - DSH_W){1'b0}}, r_dsh};
                end
                r_q[r_cnt] <= ge_c;
                r_dsh      <= r_dsh >> 1;
                r_cnt      <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // drive selection on the last step
    always_comb begin
        err_pos  = !r_err[ERR_W-1] && (r_err != '0);
        q_lo     = (r_q < origin_sel) ? origin_sel : r_q;
        q_fin    = (r_sat || (q_lo > MAX_DRIVE)) ? MAX_DRIVE : q_lo;
        mag_out  = '0;
        neg_out  = 1'b0;
        done_out = r_inside;
        pos_out  = r_pos;
        capture  = 1'b0;
        case (r_cmd)
            CMD_STOP: begin
                mag_out = '0;
            end
            CMD_FOLLOW: begin
                mag_out = r_inside ? '0 : follow_sel;
                neg_out = !err_pos;
            end
            CMD_FAST: begin
                mag_out = r_inside ? '0 : (r_prop ? q_fin : origin_sel);
                neg_out = !err_pos;
            end
            CMD_HOME: begin
                mag_out  = origin_sel;
                neg_out  = 1'b1;
                done_out = r_sw;
                if (r_sw) begin
                    // offset takes this count, so the corrected position is zero
                    mag_out = '0;
                    pos_out = '0;
                    capture = 1'b1;
                end
            end
            default: begin
                mag_out = '0;
            end
        endcase
        // switch closed: nothing moves further toward the origin
        if (neg_out && r_sw) begin
            mag_out = '0;
        end
        if (!ax_ok) begin
            mag_out  = '0;
            done_out = 1'b0;
            capture  = 1'b0;
        end
        drive_out = neg_out ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
    end

    // output register and homing capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_offset[i] <= '0;
            end
        end else begin
            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (fin_fire && capture) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    if (r_ax == 1'(i)) begin
                        r_offset[i] <= r_enc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_fire) begin
            r_out_drive <= drive_out;
            r_out_done  <= done_out;
            r_out_pos   <= ax_ok ? pos_out
                                 : {r_enc[POS_W-1], r_enc};
            r_out_ax    <= r_ax;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_tol[i]    <= 16'd10;
                r_thr[i]    <= 16'd1000;
                r_follow[i] <= 15'd200;
                r_origin[i] <= 15'd100;
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_X_TOL:    r_tol[0]    <= i_cfg_data;
                REG_Y_TOL:    r_tol[1]    <= i_cfg_data;
                REG_X_THR:    r_thr[0]    <= i_cfg_data;
                REG_Y_THR:    r_thr[1]    <= i_cfg_data;
                REG_X_FOLLOW: r_follow[0] <= i_cfg_data[DRV_W-1:0];
                REG_Y_FOLLOW: r_follow[1] <= i_cfg_data[DRV_W-1:0];
                REG_X_ORIGIN: r_origin[0] <= i_cfg_data[DRV_W-1:0];
                REG_Y_ORIGIN: r_origin[1] <= i_cfg_data[DRV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.drive    = r_out_drive;
    assign o_out.done_res = r_out_done;
    assign o_out.position = r_out_pos;
    assign o_out.axis_out = r_out_ax;

endmodule

// ===== design/apf_chk.sv =====
module apf_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_out_drive,
    input logic               i_out_done
);

    // one beat in flight: accepting a beat closes the input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still ready after a beat was taken");

    // a result is only produced while a beat is being worked on
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without a beat in progress");

    // done always means the axis is held still
    a_done_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_done) |-> (i_out_drive == 16'sd0))
        else $error("done result carries nonzero drive");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_drive) && $stable(i_out_done)))
        else $error("stalled result changed");

endmodule

bind axis_position_follow_and_homing apf_chk u_apf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_drive (o_out.drive),
    .i_out_done  (o_out.done_res)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import apf_pkg::*;

    // predictor constants
    localparam longint DRIVE_LIMIT = longint'(MAX_DRIVE);
    localparam logic signed [31:0] CNT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] CNT_MAX = 32'sh7FFF_FFFF;
    localparam int NUM_PHASES      = 11;
    localparam int TICKS_PER_PHASE = 78;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 50;

    typedef enum int {CFG_RANDOM, CFG_TOP, CFG_BOTTOM} t_cfg_style;

    // one control tick as it goes into the block
    typedef struct {
        logic               axis;
        logic [1:0]         cmd;
        logic signed [31:0] target;
        logic signed [31:0] encoder_count;
        logic               limit_switch;
    } t_tick;

    // one drive result as it comes out
    typedef struct {
        logic signed [15:0] drive;
        logic               done;
        logic signed [32:0] position;
        logic               axis;
    } t_drive_result;

    // keeps its own copy of the registers and homing offsets, predicts each
    // drive result at input acceptance and checks results in order
    class axis_drive_scoreboard;
        logic [15:0]        tol[2];
        logic [15:0]        thr[2];
        logic [14:0]        follow_mag[2];
        logic [14:0]        origin_mag[2];
        logic signed [31:0] home_offset[2];
        t_drive_result      drive_expect_q[$];
        int unsigned        mismatch_count;
        int unsigned        result_count;

        function new();
            for (int a = 0; a < 2; a++) begin
                tol[a]         = 16'd10;
                thr[a]         = 16'd1000;
                follow_mag[a]  = 15'd200;
                origin_mag[a]  = 15'd100;
                home_offset[a] = '0;
            end
            mismatch_count = 0;
            result_count   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_X_TOL:    tol[0] = data;
                REG_Y_TOL:    tol[1] = data;
                REG_X_THR:    thr[0] = data;
                REG_Y_THR:    thr[1] = data;
                REG_X_FOLLOW: follow_mag[0] = data[14:0];
                REG_Y_FOLLOW: follow_mag[1] = data[14:0];
                REG_X_ORIGIN: origin_mag[0] = data[14:0];
                REG_Y_ORIGIN: origin_mag[1] = data[14:0];
                default: ;
            endcase
        endfunction

        function t_drive_result predict_drive(t_tick t);
            t_drive_result r;
            longint pos, err, mag, q, drv, origin, follow;
            bit in_band;
            int ax;
            ax      = int'(t.axis);
            pos     = longint'(t.encoder_count) - longint'(home_offset[ax]);
            err     = longint'(t.target) - pos;
            mag     = (err < 0) ? -err : err;
            in_band = mag < longint'(tol[ax]);
            origin  = longint'(origin_mag[ax]);
            follow  = longint'(follow_mag[ax]);
            drv     = 0;
            r.done  = in_band;
            case (t.cmd)
                CMD_FOLLOW, CMD_FAST: begin
                    if (in_band) begin
                        drv = 0;
                    end else if (t.cmd == CMD_FOLLOW) begin
                        drv = (err > 0) ? follow : -follow;
                    end else if (mag > longint'(thr[ax])) begin
                        // proportional part: floor is origin drive, ceiling wins
                        if (thr[ax] == 0)
                            q = DRIVE_LIMIT;
                        else
                            q = (mag * follow) / (2 * longint'(thr[ax]));
                        if (q < origin)
                            q = origin;
                        if (q > DRIVE_LIMIT)
                            q = DRIVE_LIMIT;
                        drv = (err > 0) ? q : -q;
                    end else begin
                        drv = (err > 0) ? origin : -origin;
                    end
                    // closed switch blocks motion toward the origin
                    if (drv < 0 && t.limit_switch)
                        drv = 0;
                end
                CMD_HOME: begin
                    drv = -origin;
                    if (t.limit_switch) begin
                        home_offset[ax] = t.encoder_count;
                        drv = 0;
                    end
                    r.done = t.limit_switch;
                    pos = longint'(t.encoder_count) - longint'(home_offset[ax]);
                end
                default: ;
            endcase
            r.drive    = drv[15:0];
            r.position = pos[32:0];
            r.axis     = t.axis;
            return r;
        endfunction

        function void note_tick(t_tick t);
            drive_expect_q.push_back(predict_drive(t));
        endfunction

        function int pending();
            return drive_expect_q.size();
        endfunction

        task report(string what);
            mismatch_count++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_result(logic signed [15:0] drive, logic done,
                          logic signed [32:0] position, logic axis);
            t_drive_result want;
            result_count++;
            if (drive_expect_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing pending: drive %0d axis %0b",
                                 result_count, drive, axis));
                return;
            end
            want = drive_expect_q.pop_front();
            if (drive !== want.drive || done !== want.done ||
                position !== want.position || axis !== want.axis)
                report($sformatf({"result %0d: got drive %0d done %0b pos %0d axis %0b, ",
                                  "want drive %0d done %0b pos %0d axis %0b"},
                                 result_count, drive, done, position, axis,
                                 want.drive, want.done, want.position, want.axis));
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    logic        drain_ready   = 1'b0;
    int unsigned drain_stall   = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned src_idle_pct  = 0;

    axis_drive_scoreboard sb = new();

    apf_in_if  tick_if ();
    apf_out_if result_if ();

    assign result_if.ready = drain_ready;

    axis_position_follow_and_homing dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (tick_if),
        .o_out       (result_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side backpressure: random stall bursts
    always @(posedge i_clk) begin
        if (drain_stall != 0) begin
            drain_stall <= drain_stall - 1;
            drain_ready <= 1'b0;
        end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
            drain_stall <= $urandom_range(0, 5);
            drain_ready <= 1'b0;
        end else begin
            drain_ready <= 1'b1;
        end
    end

    // result monitor: every accepted beat is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1)
            sb.check_result(result_if.drive, result_if.done_res,
                            result_if.position, result_if.axis_out);
    end

    function automatic t_tick mk_tick(logic ax, logic [1:0] cmd, logic signed [31:0] tgt,
                                      logic signed [31:0] enc, logic sw);
        t_tick t;
        t.axis          = ax;
        t.cmd           = cmd;
        t.target        = tgt;
        t.encoder_count = enc;
        t.limit_switch  = sw;
        return t;
    endfunction

    // target placed so that the position error comes out as err
    function automatic t_tick err_tick(logic ax, logic [1:0] cmd, logic signed [31:0] enc,
                                       longint err, logic sw);
        longint tgt;
        tgt = longint'(enc) - longint'(sb.home_offset[ax]) + err;
        return mk_tick(ax, cmd, tgt[31:0], enc, sw);
    endfunction

    // random tick aimed at the dead band, the threshold and the clamp of the axis
    function automatic t_tick random_tick(logic ax);
        t_tick t;
        longint off, pos, e, tgt;
        int unsigned pick;
        bit raw;
        t.axis = ax;
        pick   = $urandom_range(0, 99);
        if (pick < 10)
            t.cmd = CMD_STOP;
        else if (pick < 35)
            t.cmd = CMD_FOLLOW;
        else if (pick < 80)
            t.cmd = CMD_FAST;
        else
            t.cmd = CMD_HOME;
        t.limit_switch = ($urandom_range(0, 3) == 0);

        // encoder either anywhere or near the current origin
        off = longint'(sb.home_offset[ax]);
        pos = off + longint'($urandom_range(0, 4000000)) - 2000000;
        if ($urandom_range(0, 3) == 0 || pos < longint'(CNT_MIN) || pos > longint'(CNT_MAX))
            t.encoder_count = $urandom;
        else
            t.encoder_count = pos[31:0];
        pos = longint'(t.encoder_count) - off;

        raw = 1'b0;
        e   = 0;
        case ($urandom_range(0, 4))
            0: e = longint'($urandom_range(0, sb.tol[ax] + 1));
            1: e = longint'(sb.thr[ax]) + longint'($urandom_range(0, 4)) - 2;
            2: e = longint'($urandom_range(sb.thr[ax], sb.thr[ax] * 24 + 100));
            3: e = longint'($urandom_range(0, 2000));
            default: raw = 1'b1;
        endcase
        if ($urandom_range(0, 1) == 1)
            e = -e;
        tgt = pos + e;
        if (raw || tgt < longint'(CNT_MIN) || tgt > longint'(CNT_MAX))
            t.target = $urandom;
        else
            t.target = tgt[31:0];
        return t;
    endfunction

    // present one beat and hold it until the block takes it
    task automatic send_tick(t_tick t);
        tick_if.valid         <= 1'b1;
        tick_if.axis          <= t.axis;
        tick_if.cmd           <= t.cmd;
        tick_if.target        <= t.target;
        tick_if.encoder_count <= t.encoder_count;
        tick_if.limit_switch  <= t.limit_switch;
        do @(posedge i_clk); while (tick_if.ready !== 1'b1);
        sb.note_tick(t);
    endtask

    task automatic source_gap();
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            tick_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // stop sending and let every pending result drain before going on
    task automatic drain_pending();
        tick_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_DAT_W-1:0] pick_reg_value(logic [CFG_IDX_W-1:0] idx,
                                                            t_cfg_style style);
        int unsigned r;
        r = $urandom_range(0, 7);
        if (style == CFG_TOP)
            return 16'hFFFF;
        if (style == CFG_BOTTOM)
            return 16'h0000;
        case (idx)
            REG_X_TOL, REG_Y_TOL: begin
                case (r)
                    0: return 16'd0;
                    1: return 16'd1;
                    2, 3: return 16'($urandom_range(2, 40));
                    4: return 16'($urandom_range(0, 16'hFFFF));
                    default: return 16'd10;
                endcase
            end
            REG_X_THR, REG_Y_THR: begin
                case (r)
                    0: return 16'd0;
                    1: return 16'hFFFF;
                    2: return 16'd1;
                    3, 4: return 16'($urandom_range(2, 3000));
                    5: return 16'($urandom_range(0, 16'hFFFF));
                    default: return 16'd1000;
                endcase
            end
            default: begin
                // follow and origin drive; bit 15 is dropped by the register
                case (r)
                    0: return 16'd0;
                    1: return 16'hFFFF;
                    2: return 16'($urandom_range(0, 16'hFFFF));
                    3: return 16'($urandom_range(990, 1010));
                    default: return 16'($urandom_range(1, 600));
                endcase
            end
        endcase
    endfunction

    task automatic program_regs(t_cfg_style style);
        logic [CFG_IDX_W-1:0] order[8];
        order = '{REG_X_TOL, REG_Y_TOL, REG_X_THR, REG_Y_THR,
                  REG_X_FOLLOW, REG_Y_FOLLOW, REG_X_ORIGIN, REG_Y_ORIGIN};
        foreach (order[i])
            write_reg(order[i], pick_reg_value(order[i], style));
        cfg_wr_en <= 1'b0;
    endtask

    // homing run: a few ticks with the switch open, the capture, then follow ticks
    task automatic home_run(logic ax);
        t_tick t;
        int unsigned n;
        n = $urandom_range(1, 4);
        repeat (n) begin
            send_tick(mk_tick(ax, CMD_HOME, $urandom, $urandom, 1'b0));
            source_gap();
        end
        send_tick(mk_tick(ax, CMD_HOME, $urandom, $urandom, 1'b1));
        source_gap();
        repeat ($urandom_range(1, 3)) begin
            t     = random_tick(ax);
            t.cmd = ($urandom_range(0, 1) == 1) ? CMD_FAST : CMD_FOLLOW;
            send_tick(t);
            source_gap();
        end
    endtask

    task automatic run_directed();
        // reset settings: dead band 10, threshold 1000, follow 200, origin 100
        send_tick(err_tick(1'b0, CMD_STOP, 0, 0, 1'b0));
        send_tick(err_tick(1'b0, CMD_FOLLOW, 123, 500, 1'b0));
        send_tick(err_tick(1'b1, CMD_FOLLOW, -77, -500, 1'b0));
        // switch closed cuts drive toward origin
        send_tick(err_tick(1'b1, CMD_FOLLOW, -77, -500, 1'b1));
        // error equal to the dead band is outside it, one less is inside
        send_tick(err_tick(1'b0, CMD_FOLLOW, 0, 10, 1'b0));
        send_tick(err_tick(1'b0, CMD_FOLLOW, 0, -9, 1'b1));
        // fast follow at the threshold stays on origin drive
        send_tick(err_tick(1'b0, CMD_FAST, 40, 1000, 1'b0));
        send_tick(err_tick(1'b0, CMD_FAST, 40, -1000, 1'b1));
        // proportional, then clamped to the drive ceiling
        send_tick(err_tick(1'b1, CMD_FAST, 0, 5000, 1'b0));
        send_tick(err_tick(1'b1, CMD_FAST, 0, -3001, 1'b0));
        send_tick(err_tick(1'b0, CMD_FAST, 0, 20000, 1'b0));
        send_tick(err_tick(1'b0, CMD_FAST, 0, 1001, 1'b0));
        send_tick(mk_tick(1'b1, CMD_FAST, CNT_MIN, CNT_MAX, 1'b1));
        // homing: drive while open, capture the offset once closed
        send_tick(mk_tick(1'b0, CMD_HOME, 0, CNT_MAX, 1'b0));
        send_tick(mk_tick(1'b0, CMD_HOME, 0, CNT_MAX, 1'b1));
        // offset-corrected position and error beyond 32 bits
        send_tick(mk_tick(1'b0, CMD_FOLLOW, CNT_MIN, CNT_MIN, 1'b0));
        send_tick(mk_tick(1'b0, CMD_STOP, CNT_MAX, CNT_MIN, 1'b0));
        send_tick(mk_tick(1'b1, CMD_HOME, CNT_MAX, CNT_MIN, 1'b1));
        send_tick(mk_tick(1'b1, CMD_FAST, CNT_MIN, CNT_MAX, 1'b0));
        send_tick(mk_tick(1'b1, CMD_STOP, 0, CNT_MIN, 1'b0));

        // x: no dead band, zero threshold, full drives; y: widest band and threshold
        drain_pending();
        write_reg(REG_X_TOL, 16'd0);
        write_reg(REG_X_THR, 16'd0);
        write_reg(REG_X_FOLLOW, 16'hFFFF);
        write_reg(REG_X_ORIGIN, 16'h7FFF);
        write_reg(REG_Y_TOL, 16'hFFFF);
        write_reg(REG_Y_THR, 16'hFFFF);
        write_reg(REG_Y_FOLLOW, 16'd1);
        write_reg(REG_Y_ORIGIN, 16'd0);
        cfg_wr_en <= 1'b0;
        // zero error outside an empty dead band goes negative on origin drive
        send_tick(err_tick(1'b0, CMD_FAST, 5, 0, 1'b0));
        // zero threshold saturates the quotient, ceiling applies
        send_tick(err_tick(1'b0, CMD_FAST, 5, 5, 1'b0));
        send_tick(err_tick(1'b0, CMD_FOLLOW, 5, 1, 1'b0));
        send_tick(err_tick(1'b1, CMD_FAST, CNT_MIN, 70000, 1'b0));
        send_tick(err_tick(1'b1, CMD_STOP, CNT_MIN, 65534, 1'b0));
        send_tick(err_tick(1'b1, CMD_FOLLOW, CNT_MIN, -65535, 1'b0));
    endtask

    initial begin
        tick_if.valid         = 1'b0;
        tick_if.axis          = 1'b0;
        tick_if.cmd           = CMD_STOP;
        tick_if.target        = '0;
        tick_if.encoder_count = '0;
        tick_if.limit_switch  = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part runs with both sides always ready to move
        run_directed();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_pending();
            if (phase == 0)
                program_regs(CFG_TOP);
            else if (phase == 1)
                program_regs(CFG_BOTTOM);
            else
                program_regs(CFG_RANDOM);

            // some phases run without idling; the last one has none at all
            if (phase == NUM_PHASES - 1 || $urandom_range(0, 3) == 0) begin
                src_idle_pct   = 0;
                sink_idle_pct <= 0;
            end else begin
                src_idle_pct   = $urandom_range(5, 40);
                sink_idle_pct <= $urandom_range(5, 40);
            end

            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                // mid-phase hold-off until the block has emptied out
                if (phase == 3 && n == TICKS_PER_PHASE / 2)
                    drain_pending();
                if ($urandom_range(0, 15) == 0)
                    home_run(1'($urandom_range(0, 1)));
                else
                    send_tick(random_tick(1'($urandom_range(0, 1))));
                source_gap();
            end
        end

        tick_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
